// File: rtl/modular_exponentiation_unit_defines.svh
// Assertion helpers for the modular exponentiation unit.
// Both expect clk and rst_n in the scope where they are used.
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MEU_ASSERT_IMP(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication.
`define MEU_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: rtl/mexp_pkg.sv
package mexp_pkg;

    localparam int RES_W      = 32;  // residue and result width
    localparam int PROD_W     = 64;  // product / dividend width
    localparam int BASE_W     = 63;
    localparam int EXP_PORT_W = 63;
    localparam int CNT_W      = 7;   // holds PROD_W

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE_START,
        ST_BASE_WAIT,
        ST_CHECK,
        ST_MUL,
        ST_RED_START,
        ST_RED_WAIT,
        ST_FINISH
    } mexp_state_t;

    typedef struct packed {
        logic load_in;
        logic base_start;
        logic base_commit;
        logic mul;
        logic red_start;
        logic red_commit;
        logic load_out;
    } mexp_cmd_t;

    typedef struct packed {
        logic red_a_done;
        logic red_s_done;
        logic exp_zero;
    } mexp_sts_t;

endpackage

// File: rtl/mexp_red.sv
module mexp_red
    import mexp_pkg::*;
#(
    parameter int MODULUS_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     full,
    input  logic                     m_zero,
    input  logic [PROD_W-1:0]        num,
    input  logic [MODULUS_WIDTH-1:0] m,
    output logic                     done,
    output logic [RES_W-1:0]         rem
);

    logic [MODULUS_WIDTH-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]        sh_reg, sh_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic [MODULUS_WIDTH:0]   trial;
    logic [MODULUS_WIDTH:0]   diff;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, sh_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, m};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            if (m_zero)
            begin
                cnt_next = '0;
            end
            else if (full)
            begin
                rem_next = '0;
                sh_next  = num;
                cnt_next = CNT_W'(PROD_W);
            end
            else
            begin
                // Product of two residues: its high half is already below m.
                rem_next = num[2*MODULUS_WIDTH-1:MODULUS_WIDTH];
                sh_next  = {num[MODULUS_WIDTH-1:0], {(PROD_W-MODULUS_WIDTH){1'b0}}};
                cnt_next = CNT_W'(MODULUS_WIDTH);
            end
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (trial >= {1'b0, m})
            begin
                rem_next = diff[MODULUS_WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[MODULUS_WIDTH-1:0];
            end
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign rem  = RES_W'(rem_reg);

endmodule

// File: rtl/mexp_dp.sv
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int MODULUS_WIDTH  = 32,
    parameter int EXPONENT_WIDTH = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mexp_cmd_t             cmd,
    output mexp_sts_t             sts,
    input  logic [BASE_W-1:0]     base,
    input  logic [EXP_PORT_W-1:0] exponent,
    input  logic [RES_W-1:0]      modulus,
    output logic [RES_W-1:0]      power
);

    logic [BASE_W-1:0]         base_reg;
    logic [EXPONENT_WIDTH-1:0] exp_reg;
    logic [MODULUS_WIDTH-1:0]  m_reg;
    logic [RES_W-1:0]          acc_reg;
    logic [RES_W-1:0]          sq_reg;
    logic [PROD_W-1:0]         pa_reg;
    logic [PROD_W-1:0]         ps_reg;
    logic [RES_W-1:0]          power_reg;

    logic                      m_zero;
    logic [PROD_W-1:0]         pa_next;
    logic [PROD_W-1:0]         ps_next;
    logic [PROD_W-1:0]         num_a;
    logic                      start_a;
    logic                      done_a;
    logic                      done_s;
    logic [RES_W-1:0]          rem_a;
    logic [RES_W-1:0]          rem_s;

    assign m_zero  = (m_reg == '0);
    assign pa_next = {{(PROD_W-RES_W){1'b0}}, acc_reg} * {{(PROD_W-RES_W){1'b0}}, sq_reg};
    assign ps_next = {{(PROD_W-RES_W){1'b0}}, sq_reg} * {{(PROD_W-RES_W){1'b0}}, sq_reg};

    // Reducer A serves the initial base reduction and the accumulator product.
    assign num_a   = cmd.base_start ? PROD_W'(base_reg) : pa_reg;
    assign start_a = cmd.base_start || cmd.red_start;

    mexp_red #(
        .MODULUS_WIDTH(MODULUS_WIDTH)
    ) u_red_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_a),
        .full   (cmd.base_start),
        .m_zero (m_zero),
        .num    (num_a),
        .m      (m_reg),
        .done   (done_a),
        .rem    (rem_a)
    );

    mexp_red #(
        .MODULUS_WIDTH(MODULUS_WIDTH)
    ) u_red_s (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.red_start),
        .full   (1'b0),
        .m_zero (m_zero),
        .num    (ps_reg),
        .m      (m_reg),
        .done   (done_s),
        .rem    (rem_s)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            base_reg <= base;
            exp_reg  <= exponent[EXPONENT_WIDTH-1:0];
            m_reg    <= modulus[MODULUS_WIDTH-1:0];
            acc_reg  <= RES_W'(1);
        end
        if (cmd.base_commit)
        begin
            sq_reg <= m_zero ? base_reg[RES_W-1:0] : rem_a;
        end
        if (cmd.mul)
        begin
            pa_reg <= pa_next;
            ps_reg <= ps_next;
        end
        if (cmd.red_commit)
        begin
            // With a zero modulus keep everything modulo 2^32.
            sq_reg <= m_zero ? ps_reg[RES_W-1:0] : rem_s;
            if (exp_reg[0])
            begin
                acc_reg <= m_zero ? pa_reg[RES_W-1:0] : rem_a;
            end
            exp_reg <= exp_reg >> 1;
        end
        if (cmd.load_out)
        begin
            power_reg <= acc_reg;
        end
    end

    assign sts.red_a_done = done_a;
    assign sts.red_s_done = done_s;
    assign sts.exp_zero   = (exp_reg == '0);
    assign power          = power_reg;

endmodule

// File: rtl/mexp_ctrl.sv
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output mexp_cmd_t cmd,
    input  mexp_sts_t sts
);

    mexp_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_BASE_START;
                end
            end
            ST_BASE_START:
            begin
                cmd.base_start = 1'b1;
                state_next     = ST_BASE_WAIT;
            end
            ST_BASE_WAIT:
            begin
                if (sts.red_a_done)
                begin
                    cmd.base_commit = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.exp_zero ? ST_FINISH : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RED_START;
            end
            ST_RED_START:
            begin
                cmd.red_start = 1'b1;
                state_next    = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                if (sts.red_a_done && sts.red_s_done)
                begin
                    cmd.red_commit = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.load_out;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/modular_exponentiation_unit.sv
// Modular exponentiation: power = base ** exponent mod modulus.
// Input channel (in_valid / in_ready) carries base, exponent and modulus;
// one transfer yields exactly one result on the output channel
// (out_valid / out_ready) carrying power. Exponent zero gives 1.
// The base is first reduced by a bit-serial remainder unit in 64 steps.
// The exponent is then scanned from its low bit, one bit per pass: a pass
// registers acc*sq and sq*sq from two 32x32 multipliers, then two remainder
// units run side by side for MODULUS_WIDTH steps. One item is worked on at
// a time; in_ready is high only while the unit is idle, so no new item is
// taken before the last one is finished. The result sits in an output
// register, so a new item is taken while an earlier result still waits
// for transfer; if the receiver stalls longer, the next result holds
// inside until the register frees. Reset empties the unit and drops any
// pending result.
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int MODULUS_WIDTH  = 32,
    parameter int EXPONENT_WIDTH = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BASE_W-1:0]     base,
    input  logic [EXP_PORT_W-1:0] exponent,
    input  logic [RES_W-1:0]      modulus,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RES_W-1:0]      power
);

    mexp_cmd_t cmd;
    mexp_sts_t sts;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mexp_dp #(
        .MODULUS_WIDTH  (MODULUS_WIDTH),
        .EXPONENT_WIDTH (EXPONENT_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .base     (base),
        .exponent (exponent),
        .modulus  (modulus),
        .power    (power)
    );

    `MEU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `MEU_ASSERT_IMP(a_no_overwrite, cmd.load_out, !(out_valid && !out_ready), "result overwritten")
    `MEU_ASSERT_IMP(a_commit_done, cmd.red_commit, sts.red_a_done && sts.red_s_done, "early commit")
    `MEU_ASSERT_IMP(a_mul_live_exp, cmd.mul, !sts.exp_zero, "multiply with exponent exhausted")

endmodule

// File: bench/tb_modular_exponentiation_unit.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit
    import mexp_pkg::*;
();

    localparam int IDLE_PCT      = 22;
    localparam int RANDOM_ITEMS  = 255;
    localparam int HOLD_AT       = 150;    // results drained before the long receiver hold
    localparam int HOLD_CYCLES   = 3000;
    localparam int WATCHDOG      = 25000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES  = 2500;

    typedef struct {
        logic [BASE_W-1:0]     base;
        logic [EXP_PORT_W-1:0] exponent;
        logic [RES_W-1:0]      modulus;
        logic [RES_W-1:0]      power;
    } mexp_job_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BASE_W-1:0]     base = '0;
    logic [EXP_PORT_W-1:0] exponent = '0;
    logic [RES_W-1:0]      modulus = 32'd1;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [RES_W-1:0]      power;

    mexp_job_t stimulus[$];
    mexp_job_t expected_powers[$];
    mexp_job_t next_job;
    mexp_job_t oldest;

    int sent_count;
    int drained;
    int hold_left;
    bit hold_done;
    int accepted_count;
    int checked_count;
    int mismatches;
    int stalled_cycles;
    int wide_exponents;

    modular_exponentiation_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .exponent  (exponent),
        .modulus   (modulus),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power     (power)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Modulus zero keeps everything modulo 2^32 instead of reducing.
    function automatic logic [63:0] reduce_mod(logic [63:0] v, logic [RES_W-1:0] m);
        if (m == '0)
        begin
            return v & 64'hFFFF_FFFF;
        end
        return v % {32'd0, m};
    endfunction

    function automatic logic [RES_W-1:0] mod_pow(logic [BASE_W-1:0] b,
                                                 logic [EXP_PORT_W-1:0] e,
                                                 logic [RES_W-1:0] m);
        logic [63:0]           acc;
        logic [63:0]           sq;
        logic [EXP_PORT_W-1:0] rest;
        acc  = 64'd1;
        sq   = reduce_mod({1'b0, b}, m);
        rest = e;
        while (rest != '0)
        begin
            if (rest[0])
            begin
                acc = reduce_mod(acc * sq, m);
            end
            sq   = reduce_mod(sq * sq, m);
            rest = rest >> 1;
        end
        return acc[RES_W-1:0];
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic void add_job(logic [BASE_W-1:0] b, logic [EXP_PORT_W-1:0] e,
                                    logic [RES_W-1:0] m);
        mexp_job_t job;
        job.base     = b;
        job.exponent = e;
        job.modulus  = m;
        job.power    = '0;
        stimulus = {stimulus, job};
        if (e > 63'hFFFF_FFFF)
        begin
            wide_exponents++;
        end
    endfunction

    // Sender: hold the payload until transfer, idle at random outside the steady window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (stimulus.size() > 0 &&
                ((sent_count >= 60 && sent_count < 120) || $urandom_range(99) >= IDLE_PCT))
            begin
                next_job = stimulus.pop_front();
                sent_count++;
                in_valid <= 1'b1;
                base     <= next_job.base;
                exponent <= next_job.exponent;
                modulus  <= next_job.modulus;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold so the unit backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            drained   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                drained <= drained + 1;
            end
            if (!hold_done && drained >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= (drained >= 60 && drained < 120) ||
                             ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Check each result transfer against the oldest prediction, then log new input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual power=%h",
                             $time, power);
                end
                else
                begin
                    oldest = expected_powers.pop_front();
                    checked_count++;
                    if (power !== oldest.power)
                    begin
                        mismatches++;
                        $display("%0t power mismatch (base=%h exponent=%h modulus=%h):",
                                 $time, oldest.base, oldest.exponent, oldest.modulus);
                        $display("%0t     expected %h actual %h",
                                 $time, oldest.power, power);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                oldest.base     = base;
                oldest.exponent = exponent;
                oldest.modulus  = modulus;
                oldest.power    = mod_pow(base, exponent, modulus);
                expected_powers = {expected_powers, oldest};
                accepted_count++;
            end
            if (hold_left > 0 && in_valid && !in_ready)
            begin
                stalled_cycles++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t watchdog expired with %0d results outstanding",
                 $time, expected_powers.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus_gen
        int                    i;
        int                    kind;
        int                    pick;
        int                    len;
        logic [BASE_W-1:0]     b;
        logic [EXP_PORT_W-1:0] e;
        logic [RES_W-1:0]      m;

        // zero exponent gives one, even for modulus one
        add_job(63'd12345, 63'd0, 32'd1);
        add_job({63{1'b1}}, 63'd0, 32'hFFFF_FFFF);
        // modulus one with a nonzero exponent gives zero
        add_job(63'd77, 63'd9, 32'd1);
        add_job(63'd0, 63'd5, 32'd97);
        add_job({63{1'b1}}, {63{1'b1}}, 32'hFFFF_FFFF);
        add_job({63{1'b1}}, 63'd1, 32'hFFFF_FFFF);
        add_job(63'd1, {63{1'b1}}, 32'd2);
        add_job(63'd3, 63'd100, 32'h8000_0000);
        add_job(63'd1000003, 63'd3, 32'd1000003);
        add_job(63'd41, 63'd1, 32'd1000);
        // Fermat: 2^(p-1) mod p for a prime near 2^32
        add_job(63'd2, 63'hFFFF_FFFA, 32'hFFFF_FFFB);
        add_job(63'd7, 63'h4000_0000_0000_0000, 32'd1000003);
        add_job(63'h1_0000_0000, 63'd2, 32'hFFFF_FFFF);
        add_job(63'd6, 63'd11, 32'd2);
        add_job(63'd5, 63'd11, 32'd2);
        add_job(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        add_job(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(99);
            pick = $urandom_range(9);
            case (pick)
                0: m = $urandom_range(16, 1);
                1: m = 32'hFFFF_FFFF - $urandom_range(7);
                2: m = 32'd1 << $urandom_range(31);
                default: m = $urandom;
            endcase
            if (m == '0)
            begin
                m = 32'd1;
            end
            pick = $urandom_range(9);
            case (pick)
                0: b = BASE_W'($urandom_range(3));
                1: b = {31'd0, m} * BASE_W'($urandom_range(5));
                default: b = rand63();
            endcase
            // keep most exponents short; full-width ones dominate run time
            if (kind < 10)
            begin
                e = rand63();
            end
            else if (kind < 20)
            begin
                e = EXP_PORT_W'($urandom_range(1));
            end
            else
            begin
                len = $urandom_range(12, 1);
                e = rand63() & ((63'd1 << len) - 63'd1);
            end
            add_job(b, e, m);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (stimulus.size() != 0 || in_valid || expected_powers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d transfers, %0d with exponents wider than 32 bits.",
                 checked_count, accepted_count, wide_exponents);
        $display("Input held back for %0d cycles while the receiver stalled.",
                 stalled_cycles);
        if (mismatches == 0 && expected_powers.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_red.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_unit.sv
bench/tb_modular_exponentiation_unit.sv
